FILE: rtl/pls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and constants for the positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int unsigned CapacityDef = 16;
  localparam int unsigned DataW       = 32;
  localparam int unsigned PosW        = 5;
  localparam int unsigned LenW        = 5;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_e;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [PosW-1:0] pos;
  } pls_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/pls_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pls_cell
// One entry of the list. Shifts up from the left neighbor on insert or loads
// new value at its position; down from the right neighbor on remove, or holds.
// ----------------------------------------------------------------------------
module pls_cell #(
  parameter int unsigned Idx = 0
) (
  input  wire logic                         clk_i,
  input  wire pls_pkg::pls_ctrl_t           ctrl_i,
  input  wire logic [pls_pkg::DataW-1:0]    value_i,
  input  wire logic [pls_pkg::DataW-1:0]    left_i,
  input  wire logic [pls_pkg::DataW-1:0]    right_i,
  output logic      [pls_pkg::DataW-1:0]    data_o,
  output logic      [pls_pkg::DataW-1:0]    rd_o
);

  logic [pls_pkg::DataW-1:0] data_q, data_d;
  logic                      hit, above;

  assign hit   = (32'(ctrl_i.pos) == 32'(Idx));
  assign above = (32'(ctrl_i.pos) <  32'(Idx));

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (above) begin
        data_d = left_i;
      end else if (hit) begin
        data_d = value_i;
      end
    end else if (ctrl_i.rem) begin
      if (above || hit) begin
        data_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = hit ? data_q : '0;

endmodule
`default_nettype wire

FILE: rtl/positional_list_store_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_store_unit
// Ordered list of up to CAPACITY signed 32-bit entries with positional
// insert, remove, read and clear.
// ----------------------------------------------------------------------------
// Each request is applied on acceptance and its result is registered, so one
// transfer per clock is sustained while the output side keeps up; a stalled
// output holds the input off. The entries live in a row of cells that all
// shift or hold in the same cycle from a compare against the request
// position; a read is a one-hot select across the row. Positions are 5 bits,
// so only the first 32 cells are reachable. length reports the low 5 bits of
// the entry count.
// ----------------------------------------------------------------------------
module positional_list_store_unit #(
  parameter int unsigned CAPACITY = pls_pkg::CapacityDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [1:0]                        req_type_i,
  input  wire logic [pls_pkg::PosW-1:0]          position_i,
  input  wire logic signed [pls_pkg::DataW-1:0]  value_in_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   ok_o,
  output logic signed [pls_pkg::DataW-1:0]       value_out_o,
  output logic [pls_pkg::LenW-1:0]               length_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > pls_pkg::PosW) ? CntW : pls_pkg::PosW;

  logic                      accept;
  logic [CntW-1:0]           count_q, count_d;
  logic [CmpW-1:0]           pos_w, cnt_w;
  logic                      ins_ok, rem_ok, rd_ok, clr, in_range, not_full;
  pls_pkg::pls_ctrl_t        ctrl;
  logic [pls_pkg::DataW-1:0] data [CAPACITY];
  logic [pls_pkg::DataW-1:0] rd   [CAPACITY];
  logic [pls_pkg::DataW-1:0] rd_sel;

  logic                      out_valid_q;
  logic                      ok_q;
  logic [pls_pkg::DataW-1:0] value_q;
  logic [pls_pkg::LenW-1:0]  length_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign pos_w    = CmpW'(position_i);
  assign cnt_w    = CmpW'(count_q);
  assign in_range = pos_w < cnt_w;
  assign not_full = count_q < CntW'(CAPACITY);

  assign ins_ok = accept && (req_type_i == pls_pkg::REQ_INSERT) && (pos_w <= cnt_w) && not_full;
  assign rem_ok = accept && (req_type_i == pls_pkg::REQ_REMOVE) && in_range;
  assign rd_ok  = accept && (req_type_i == pls_pkg::REQ_READ) && in_range;
  assign clr    = accept && (req_type_i == pls_pkg::REQ_CLEAR);

  assign ctrl.ins = ins_ok;
  assign ctrl.rem = rem_ok;
  assign ctrl.pos = position_i;

  always_comb begin
    count_d = count_q;
    priority if (clr) begin
      count_d = '0;
    end else if (ins_ok) begin
      count_d = count_q + CntW'(1);
    end else if (rem_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [pls_pkg::DataW-1:0] left, right;
    if (k == 0) begin : g_first
      assign left = value_in_i;
    end else begin : g_mid_l
      assign left = data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = data[k+1];
    end
    pls_cell #(
      .Idx(k)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .value_i(value_in_i),
      .left_i (left),
      .right_i(right),
      .data_o (data[k]),
      .rd_o   (rd[k])
    );
  end

  always_comb begin
    rd_sel = '0;
    for (int unsigned k = 0; k < CAPACITY; k++) begin
      rd_sel = rd_sel | rd[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q     <= ins_ok || rem_ok || rd_ok || clr;
      value_q  <= rd_ok ? rd_sel : '0;
      length_q <= pls_pkg::LenW'(count_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign value_out_o = value_q;
  assign length_o    = length_q;

endmodule
`default_nettype wire

FILE: tb/tb_positional_list_store_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_store_unit
// Self-checking bench for the positional list store.
// ----------------------------------------------------------------------------
// A short directed run covers the edge cases: empty reads and removes, insert
// past the end, front and back inserts, extreme values and positions, and
// clear. Random phases then follow. Fill phases drive the store to full, drain
// phases empty it, and mixed and noise phases cover the rest, with random
// gaps on both sides. A scoreboard keeps its own copy of the list and checks
// every response in order.
// ----------------------------------------------------------------------------

typedef struct {
  logic                              ok;
  logic signed [pls_pkg::DataW-1:0]  value;
  logic [pls_pkg::LenW-1:0]          len;
} list_reply_t;

class list_scoreboard;
  localparam int Cap = pls_pkg::CapacityDef;

  logic signed [pls_pkg::DataW-1:0] entries[Cap];
  int          count;
  list_reply_t replies[$];
  int          errors;
  int          checked;
  int          kind_seen[4];
  int          rejects;
  int          full_rejects;
  int          peak;

  function new();
    count        = 0;
    errors       = 0;
    checked      = 0;
    rejects      = 0;
    full_rejects = 0;
    peak         = 0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    foreach (entries[i]) entries[i] = '0;
  endfunction

  function int pending();
    return replies.size();
  endfunction

  function void note_request(pls_pkg::req_e kind, logic [pls_pkg::PosW-1:0] pos,
                             logic signed [pls_pkg::DataW-1:0] val);
    list_reply_t r;
    int          p;
    p       = int'(pos);
    r.ok    = 1'b0;
    r.value = '0;
    kind_seen[kind]++;
    case (kind)
      pls_pkg::REQ_INSERT: begin
        if (p <= count && count < Cap) begin
          for (int k = count; k > p; k--) entries[k] = entries[k-1];
          entries[p] = val;
          count++;
          r.ok = 1'b1;
        end else if (count == Cap) begin
          full_rejects++;
        end
      end
      pls_pkg::REQ_REMOVE: begin
        if (p < count) begin
          for (int k = p; k + 1 < count; k++) entries[k] = entries[k+1];
          count--;
          r.ok = 1'b1;
        end
      end
      pls_pkg::REQ_READ: begin
        if (p < count) begin
          r.value = entries[p];
          r.ok    = 1'b1;
        end
      end
      default: begin
        count = 0;
        r.ok  = 1'b1;
      end
    endcase
    if (!r.ok) rejects++;
    if (count > peak) peak = count;
    r.len = count[pls_pkg::LenW-1:0];
    replies.push_back(r);
  endfunction

  function void check_result(logic ok, logic signed [pls_pkg::DataW-1:0] val,
                             logic [pls_pkg::LenW-1:0] len);
    list_reply_t e;
    if (replies.size() == 0) begin
      errors++;
      $display("%0t: unexpected response ok=%0b value=%0d length=%0d", $time, ok, val, len);
      return;
    end
    e = replies.pop_front();
    checked++;
    if (ok !== e.ok) begin
      errors++;
      $display("%0t: ok mismatch, expected %0b got %0b", $time, e.ok, ok);
    end
    if (val !== e.value) begin
      errors++;
      $display("%0t: value_out mismatch, expected %0d got %0d", $time, e.value, val);
    end
    if (len !== e.len) begin
      errors++;
      $display("%0t: length mismatch, expected %0d got %0d", $time, e.len, len);
    end
  endfunction
endclass

module tb_positional_list_store_unit;
  import pls_pkg::*;

  localparam int Cap        = pls_pkg::CapacityDef;
  localparam int NumItems   = 600;
  localparam int CycleLimit = 500_000;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} phase_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid;
  logic                     in_ready;
  logic [1:0]               req_type;
  logic [PosW-1:0]          position;
  logic signed [DataW-1:0]  value_in;
  logic                     out_valid;
  logic                     out_ready;
  logic                     ok;
  logic signed [DataW-1:0]  value_out;
  logic [LenW-1:0]          length;

  list_scoreboard sb = new();
  int             cycles;
  int             sent;

  positional_list_store_unit #(
    .CAPACITY(Cap)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .req_type_i  (req_type),
    .position_i  (position),
    .value_in_i  (value_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .ok_o        (ok),
    .value_out_o (value_out),
    .length_o    (length)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) sb.check_result(ok, value_out, length);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic req_e pick_kind(phase_e ph);
    int r;
    r = $urandom_range(99, 0);
    case (ph)
      PH_FILL: begin
        if (r < 78) return REQ_INSERT;
        if (r < 93) return REQ_READ;
        if (r < 99) return REQ_REMOVE;
      end
      PH_DRAIN: begin
        if (r < 65) return REQ_REMOVE;
        if (r < 85) return REQ_READ;
        if (r < 97) return REQ_INSERT;
      end
      PH_MIXED: begin
        if (r < 35) return REQ_INSERT;
        if (r < 60) return REQ_REMOVE;
        if (r < 95) return REQ_READ;
      end
      default: begin
        if (r < 25) return REQ_INSERT;
        if (r < 50) return REQ_REMOVE;
        if (r < 75) return REQ_READ;
      end
    endcase
    return REQ_CLEAR;
  endfunction

  function automatic logic [PosW-1:0] pick_pos(req_e kind, phase_e ph);
    int c;
    c = sb.count;
    if (ph == PH_NOISE || $urandom_range(9, 0) == 0) return PosW'($urandom_range(31, 0));
    if (kind == REQ_INSERT) return PosW'($urandom_range(c, 0));
    if (c == 0) return '0;
    return PosW'($urandom_range(c - 1, 0));
  endfunction

  function automatic logic signed [DataW-1:0] pick_value();
    if ($urandom_range(7, 0) != 0) return $urandom();
    case ($urandom_range(3, 0))
      0:       return 32'sh0000_0000;
      1:       return 32'shFFFF_FFFF;
      2:       return 32'sh7FFF_FFFF;
      default: return 32'sh8000_0000;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic issue_request(req_e kind, logic [PosW-1:0] pos, logic signed [DataW-1:0] val);
    in_valid = 1'b1;
    req_type = kind;
    position = pos;
    value_in = val;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sb.note_request(kind, pos, val);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic idle_sender(int gap);
    if (gap == 0) return;
    in_valid = 1'b0;
    req_type = 2'($urandom_range(3, 0));
    position = PosW'($urandom_range(31, 0));
    value_in = $urandom();
    repeat (gap) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  initial begin
    int burst;
    int stall;
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      burst = ($urandom_range(9, 0) == 0) ? $urandom_range(150, 40) : $urandom_range(12, 1);
      out_ready = 1'b1;
      repeat (burst) @(negedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  initial begin
    phase_e ph;
    int     plen;
    bit     calm;
    bit     first;
    req_e   kind;

    cycles   = 0;
    sent     = 0;
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    req_type = REQ_INSERT;
    position = '0;
    value_in = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed edge cases
    issue_request(REQ_READ,   5'd0,  32'sh1234_5678);
    issue_request(REQ_REMOVE, 5'd0,  32'sh0);
    issue_request(REQ_INSERT, 5'd1,  32'sh1111_1111);
    issue_request(REQ_INSERT, 5'd0,  32'sh7FFF_FFFF);
    issue_request(REQ_INSERT, 5'd0,  32'sh8000_0000);
    issue_request(REQ_INSERT, 5'd2,  32'shFFFF_FFFF);
    issue_request(REQ_INSERT, 5'd1,  32'sh0000_0000);
    issue_request(REQ_READ,   5'd0,  32'sh0);
    issue_request(REQ_READ,   5'd1,  32'sh0);
    issue_request(REQ_READ,   5'd3,  32'sh0);
    issue_request(REQ_READ,   5'd31, 32'sh0);
    issue_request(REQ_INSERT, 5'd31, 32'sh5555_5555);
    issue_request(REQ_INSERT, 5'd16, 32'shAAAA_AAAA);
    issue_request(REQ_REMOVE, 5'd3,  32'sh0);
    issue_request(REQ_REMOVE, 5'd0,  32'sh0);
    issue_request(REQ_READ,   5'd1,  32'sh0);
    issue_request(REQ_CLEAR,  5'd31, 32'shFFFF_FFFF);
    issue_request(REQ_READ,   5'd0,  32'sh0);
    issue_request(REQ_REMOVE, 5'd31, 32'sh0);
    wait_drained();

    first = 1'b1;
    while (sent < NumItems + 19) begin
      case ($urandom_range(9, 0))
        0, 1, 2: ph = PH_FILL;
        3, 4:    ph = PH_DRAIN;
        9:       ph = PH_NOISE;
        default: ph = PH_MIXED;
      endcase
      plen = $urandom_range(80, 30);
      calm = ($urandom_range(3, 0) == 0);
      repeat (plen) begin
        kind = pick_kind(ph);
        issue_request(kind, pick_pos(kind, ph), pick_value());
        idle_sender(calm ? 0 : pick_gap());
      end
      if (first || $urandom_range(2, 0) == 0) wait_drained();
      first = 1'b0;
    end

    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("%0d transfers checked: %0d insert, %0d remove, %0d read, %0d clear",
             sb.checked, sb.kind_seen[REQ_INSERT], sb.kind_seen[REQ_REMOVE],
             sb.kind_seen[REQ_READ], sb.kind_seen[REQ_CLEAR]);
    $display("%0d rejected (%0d on a full list), peak length %0d, %0d errors",
             sb.rejects, sb.full_rejects, sb.peak, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
